[hdl/qxmm_pkg.sv]
// qxmm_pkg: widths, types, register codes and the mixing table for the
// quad x-frame motor mixer. Used by every other file; depends on nothing.
`timescale 1ns / 1ps

package qxmm_pkg;

   // fixed-point scale of the motor levels, 1.0 = 1 << FRAC_BITS
   localparam int FRAC_BITS  = 14;
   localparam int LEVEL_W    = FRAC_BITS + 1;
   localparam int ONE_LEVEL  = 1 << FRAC_BITS;
   localparam int HALF_LEVEL = 1 << (FRAC_BITS - 1);

   localparam int CMD_W      = 16;
   localparam int CFG_W      = 15;
   localparam int PULSE_W    = 16;
   localparam int CSR_DATA_W = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int LANES      = 4;

   localparam int AXIS_W     = CMD_W + 2;
   localparam int RANGE_W    = AXIS_W + 1;
   localparam int AVAIL_W    = CFG_W + 1;
   localparam int PROD_W     = AXIS_W + AVAIL_W;
   localparam int NUM_W      = 32;
   localparam int DEN_W      = AXIS_W;
   localparam int DIV_STEP   = 4;
   localparam int DIV_STAGES = NUM_W / DIV_STEP;
   localparam int SCALED_W   = NUM_W + 1;
   localparam int BOUND_W    = SCALED_W + 1;
   localparam int LVL_W      = BOUND_W + 1;
   localparam int DIFF_W     = PULSE_W + 1;
   localparam int PWR_W      = LEVEL_W + 1 + DIFF_W;

   typedef logic signed [CMD_W-1:0]    cmd_type;
   typedef logic signed [AXIS_W-1:0]   axis_type;
   typedef logic signed [RANGE_W-1:0]  range_type;
   typedef logic signed [AVAIL_W-1:0]  avail_type;
   typedef logic signed [PROD_W-1:0]   prod_type;
   typedef logic        [NUM_W-1:0]    num_type;
   typedef logic        [DEN_W-1:0]    den_type;
   typedef logic signed [SCALED_W-1:0] scaled_type;
   typedef logic signed [BOUND_W-1:0]  bound_type;
   typedef logic signed [LVL_W-1:0]    lvl_type;
   typedef logic        [LEVEL_W-1:0]  level_type;
   typedef logic signed [DIFF_W-1:0]   diff_type;
   typedef logic signed [PWR_W-1:0]    pwr_type;
   typedef logic        [PULSE_W-1:0]  pulse_type;
   typedef logic        [CFG_W-1:0]    frac_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_IDLE_LEVEL     = 3'd0,
      CSR_MAX_LEVEL      = 3'd1,
      CSR_DESAT_THROTTLE = 3'd2,
      CSR_PULSE_MIN      = 3'd3,
      CSR_PULSE_MAX      = 3'd4
   } csr_index_type;

   typedef struct packed {
      frac_type  idle_level;
      frac_type  max_level;
      frac_type  desat_throttle;
      pulse_type pulse_min;
      pulse_type pulse_max;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      idle_level:     15'd0,
      max_level:      15'd16384,
      desat_throttle: 15'd819,
      pulse_min:      16'd1000,
      pulse_max:      16'd2000
   };

   // one item moving through the divider, all four motors side by side
   typedef struct packed {
      logic [LANES-1:0][NUM_W-1:0] work;
      logic [LANES-1:0][DEN_W-1:0] rem;
      den_type                     den;
      logic [LANES-1:0]            neg;
      logic                        flip;
      cmd_type                     thr;
      logic                        armed;
   } div_type;

   // negated axes per motor, bit 0 roll, bit 1 pitch, bit 2 yaw
   // motor order: front right, rear right, rear left, front left
   localparam logic [LANES-1:0][2:0] MIX_NEG = {3'b100, 3'b010, 3'b111, 3'b001};

   function automatic axis_type mix_axis(input cmd_type roll, input cmd_type pitch,
                                         input cmd_type yaw, input logic [2:0] neg);
      axis_type r;
      axis_type p;
      axis_type y;
      r = axis_type'(roll);
      p = axis_type'(pitch);
      y = axis_type'(yaw);
      if (neg[0]) r = -r;
      if (neg[1]) p = -p;
      if (neg[2]) y = -y;
      return r + p + y;
   endfunction

endpackage

[hdl/qxmm_if.sv]
// request and response channel interfaces of the motor mixer
// depends on qxmm_pkg for the payload types
`timescale 1ns / 1ps

interface qxmm_req_if;
   logic                valid;
   logic                ready;
   qxmm_pkg::cmd_type   roll_cmd;
   qxmm_pkg::cmd_type   pitch_cmd;
   qxmm_pkg::cmd_type   yaw_cmd;
   qxmm_pkg::cmd_type   throttle_cmd;
   logic                armed;

   modport source (output valid, roll_cmd, pitch_cmd, yaw_cmd, throttle_cmd, armed,
                   input ready);
   modport sink   (input valid, roll_cmd, pitch_cmd, yaw_cmd, throttle_cmd, armed,
                   output ready);
endinterface

interface qxmm_rsp_if;
   logic                valid;
   logic                ready;
   qxmm_pkg::pulse_type pulse_front_right;
   qxmm_pkg::pulse_type pulse_rear_right;
   qxmm_pkg::pulse_type pulse_rear_left;
   qxmm_pkg::pulse_type pulse_front_left;

   modport source (output valid, pulse_front_right, pulse_rear_right, pulse_rear_left,
                   pulse_front_left, input ready);
   modport sink   (input valid, pulse_front_right, pulse_rear_right, pulse_rear_left,
                   pulse_front_left, output ready);
endinterface

[hdl/qxmm_front.sv]
// front end: axis mixing, min/max and spread, desaturation product and
// divider operand setup in four register stages. Depends on qxmm_pkg, qxmm_if.
`timescale 1ns / 1ps

module qxmm_front (
   input  logic              clock,
   input  logic              reset,
   qxmm_req_if.sink          req,
   input  qxmm_pkg::cfg_type cfg,
   output logic              out_valid,
   input  logic              out_ready,
   output qxmm_pkg::div_type out_item
);

   logic s1_ready, s2_ready, s3_ready, s4_ready;
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff;

   qxmm_pkg::axis_type  s1_axis_in [qxmm_pkg::LANES];
   qxmm_pkg::axis_type  s1_axis_ff [qxmm_pkg::LANES];
   qxmm_pkg::cmd_type   s1_thr_ff;
   logic                s1_armed_ff;

   qxmm_pkg::axis_type  lo_a, lo_b, lo_m, hi_a, hi_b, hi_m;
   qxmm_pkg::range_type range;
   qxmm_pkg::avail_type avail;
   logic                scale;
   qxmm_pkg::axis_type  s2_axis_ff [qxmm_pkg::LANES];
   qxmm_pkg::cmd_type   s2_thr_ff;
   logic                s2_armed_ff;
   qxmm_pkg::avail_type s2_avail_in, s2_avail_ff;
   qxmm_pkg::den_type   s2_den_in, s2_den_ff;
   logic                s2_flip_in, s2_flip_ff;

   qxmm_pkg::prod_type  s3_p_in [qxmm_pkg::LANES];
   qxmm_pkg::prod_type  s3_p_ff [qxmm_pkg::LANES];
   qxmm_pkg::den_type   s3_den_ff;
   qxmm_pkg::cmd_type   s3_thr_ff;
   logic                s3_armed_ff;
   logic                s3_flip_ff;

   qxmm_pkg::prod_type  mag [qxmm_pkg::LANES];
   qxmm_pkg::div_type   s4_item_in, s4_item_ff;

   assign s4_ready  = !s4_valid_ff || out_ready;
   assign s3_ready  = !s3_valid_ff || s4_ready;
   assign s2_ready  = !s2_valid_ff || s3_ready;
   assign s1_ready  = !s1_valid_ff || s2_ready;
   assign req.ready = s1_ready;
   assign out_valid = s4_valid_ff;
   assign out_item  = s4_item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         if (s1_ready) s1_valid_ff <= req.valid;
         if (s2_ready) s2_valid_ff <= s1_valid_ff;
         if (s3_ready) s3_valid_ff <= s2_valid_ff;
         if (s4_ready) s4_valid_ff <= s3_valid_ff;
      end
   end

   // stage 1: x-frame sign matrix
   always_comb begin
      for (int l = 0; l < qxmm_pkg::LANES; l++) begin
         s1_axis_in[l] = qxmm_pkg::mix_axis(req.roll_cmd, req.pitch_cmd, req.yaw_cmd,
                                            qxmm_pkg::MIX_NEG[l]);
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready && req.valid) begin
         for (int l = 0; l < qxmm_pkg::LANES; l++) s1_axis_ff[l] <= s1_axis_in[l];
         s1_thr_ff   <= req.throttle_cmd;
         s1_armed_ff <= req.armed;
      end
   end

   // stage 2: spread of the mixed axes against the available headroom
   always_comb begin
      if (s1_axis_ff[1] < s1_axis_ff[0]) begin
         lo_a = s1_axis_ff[1];
         hi_a = s1_axis_ff[0];
      end else begin
         lo_a = s1_axis_ff[0];
         hi_a = s1_axis_ff[1];
      end
      if (s1_axis_ff[3] < s1_axis_ff[2]) begin
         lo_b = s1_axis_ff[3];
         hi_b = s1_axis_ff[2];
      end else begin
         lo_b = s1_axis_ff[2];
         hi_b = s1_axis_ff[3];
      end
      lo_m  = (lo_b < lo_a) ? lo_b : lo_a;
      hi_m  = (hi_b > hi_a) ? hi_b : hi_a;
      range = qxmm_pkg::range_type'(hi_m) - qxmm_pkg::range_type'(lo_m);
      avail = qxmm_pkg::avail_type'(cfg.max_level) - qxmm_pkg::avail_type'(cfg.idle_level);
      scale = (range > qxmm_pkg::range_type'(avail)) && (range > 0);
      // without desaturation the divider runs as a divide by one
      s2_den_in   = scale ? range[qxmm_pkg::DEN_W-1:0] : qxmm_pkg::den_type'(1);
      s2_avail_in = scale ? avail : qxmm_pkg::avail_type'(1);
      s2_flip_in  = scale && avail[qxmm_pkg::AVAIL_W-1];
   end

   always_ff @(posedge clock) begin
      if (s2_ready && s1_valid_ff) begin
         for (int l = 0; l < qxmm_pkg::LANES; l++) s2_axis_ff[l] <= s1_axis_ff[l];
         s2_thr_ff   <= s1_thr_ff;
         s2_armed_ff <= s1_armed_ff;
         s2_avail_ff <= s2_avail_in;
         s2_den_ff   <= s2_den_in;
         s2_flip_ff  <= s2_flip_in;
      end
   end

   // stage 3: axis times headroom
   always_comb begin
      for (int l = 0; l < qxmm_pkg::LANES; l++) begin
         s3_p_in[l] = qxmm_pkg::prod_type'(s2_axis_ff[l]) *
                      qxmm_pkg::prod_type'(s2_avail_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (s3_ready && s2_valid_ff) begin
         for (int l = 0; l < qxmm_pkg::LANES; l++) s3_p_ff[l] <= s3_p_in[l];
         s3_den_ff   <= s2_den_ff;
         s3_thr_ff   <= s2_thr_ff;
         s3_armed_ff <= s2_armed_ff;
         s3_flip_ff  <= s2_flip_ff;
      end
   end

   // stage 4: magnitude plus half divisor, rounds ties away from zero
   always_comb begin
      s4_item_in.den   = s3_den_ff;
      s4_item_in.flip  = s3_flip_ff;
      s4_item_in.thr   = s3_thr_ff;
      s4_item_in.armed = s3_armed_ff;
      s4_item_in.rem   = '0;
      for (int l = 0; l < qxmm_pkg::LANES; l++) begin
         mag[l] = s3_p_ff[l][qxmm_pkg::PROD_W-1] ? -s3_p_ff[l] : s3_p_ff[l];
         s4_item_in.neg[l]  = s3_p_ff[l][qxmm_pkg::PROD_W-1];
         s4_item_in.work[l] = mag[l][qxmm_pkg::NUM_W-1:0] +
                              qxmm_pkg::num_type'(s3_den_ff >> 1);
      end
   end

   always_ff @(posedge clock) begin
      if (s4_ready && s3_valid_ff) begin
         s4_item_ff <= s4_item_in;
      end
   end

endmodule

[hdl/qxmm_div_stage.sv]
// one stage of the pipelined restoring divider, four quotient bits per
// stage for all four motors. Depends on qxmm_pkg.
`timescale 1ns / 1ps

module qxmm_div_stage (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  qxmm_pkg::div_type in_item,
   output logic              out_valid,
   input  logic              out_ready,
   output qxmm_pkg::div_type out_item
);

   logic                     valid_ff;
   qxmm_pkg::div_type        item_in, item_ff;
   logic [qxmm_pkg::DEN_W:0] trial;
   qxmm_pkg::num_type        work_w;
   qxmm_pkg::den_type        rem_w;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_item  = item_ff;

   // dividend bits leave the top of work, quotient bits enter at the bottom
   always_comb begin
      item_in = in_item;
      trial   = '0;
      work_w  = '0;
      rem_w   = '0;
      for (int l = 0; l < qxmm_pkg::LANES; l++) begin
         rem_w  = in_item.rem[l];
         work_w = in_item.work[l];
         for (int s = 0; s < qxmm_pkg::DIV_STEP; s++) begin
            trial  = {rem_w, work_w[qxmm_pkg::NUM_W-1]};
            work_w = work_w << 1;
            if (trial >= {1'b0, in_item.den}) begin
               trial     = trial - {1'b0, in_item.den};
               work_w[0] = 1'b1;
            end
            rem_w = trial[qxmm_pkg::DEN_W-1:0];
         end
         item_in.rem[l]  = rem_w;
         item_in.work[l] = work_w;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         item_ff <= item_in;
      end
   end

endmodule

[hdl/qxmm_back.sv]
// back end: signed scaled axes, scaled min/max, throttle bound, motor level
// clamp, pulse mapping and output register. Depends on qxmm_pkg, qxmm_if.
`timescale 1ns / 1ps

module qxmm_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  qxmm_pkg::div_type in_item,
   input  qxmm_pkg::cfg_type cfg,
   qxmm_rsp_if.source        rsp
);

   logic b1_ready, b2_ready, b3_ready, b4_ready, b5_ready, b6_ready;
   logic b1_valid_ff, b2_valid_ff, b3_valid_ff, b4_valid_ff, b5_valid_ff, b6_valid_ff;

   qxmm_pkg::scaled_type b1_mag [qxmm_pkg::LANES];
   qxmm_pkg::scaled_type b1_axis_in [qxmm_pkg::LANES];
   qxmm_pkg::scaled_type b1_axis_ff [qxmm_pkg::LANES];
   logic                 b1_flip_ff;
   qxmm_pkg::cmd_type    b1_thr_ff;
   logic                 b1_armed_ff;

   qxmm_pkg::scaled_type lo_a, lo_b, lo_m, hi_a, hi_b, hi_m;
   qxmm_pkg::scaled_type b2_lo_in, b2_hi_in, b2_lo_ff, b2_hi_ff;
   qxmm_pkg::scaled_type b2_axis_ff [qxmm_pkg::LANES];
   qxmm_pkg::cmd_type    b2_thr_ff;
   logic                 b2_armed_ff;

   qxmm_pkg::bound_type  floor_v, ceil_v, thr_e;
   qxmm_pkg::bound_type  b3_thr_in, b3_thr_ff;
   qxmm_pkg::scaled_type b3_axis_ff [qxmm_pkg::LANES];
   logic                 b3_armed_ff;

   qxmm_pkg::lvl_type    idle_e, max_e;
   qxmm_pkg::lvl_type    lvl [qxmm_pkg::LANES];
   qxmm_pkg::lvl_type    bnd [qxmm_pkg::LANES];
   qxmm_pkg::level_type  b4_v_in [qxmm_pkg::LANES];
   qxmm_pkg::level_type  b4_v_ff [qxmm_pkg::LANES];

   qxmm_pkg::diff_type   span;
   qxmm_pkg::pwr_type    b5_n_in [qxmm_pkg::LANES];
   qxmm_pkg::pwr_type    b5_n_ff [qxmm_pkg::LANES];

   qxmm_pkg::pwr_type    q [qxmm_pkg::LANES];
   qxmm_pkg::pulse_type  b6_pulse_in [qxmm_pkg::LANES];
   qxmm_pkg::pulse_type  b6_pulse_ff [qxmm_pkg::LANES];

   assign b6_ready = !b6_valid_ff || rsp.ready;
   assign b5_ready = !b5_valid_ff || b6_ready;
   assign b4_ready = !b4_valid_ff || b5_ready;
   assign b3_ready = !b3_valid_ff || b4_ready;
   assign b2_ready = !b2_valid_ff || b3_ready;
   assign b1_ready = !b1_valid_ff || b2_ready;
   assign in_ready = b1_ready;

   assign rsp.valid             = b6_valid_ff;
   assign rsp.pulse_front_right = b6_pulse_ff[0];
   assign rsp.pulse_rear_right  = b6_pulse_ff[1];
   assign rsp.pulse_rear_left   = b6_pulse_ff[2];
   assign rsp.pulse_front_left  = b6_pulse_ff[3];

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_valid_ff <= 1'b0;
         b2_valid_ff <= 1'b0;
         b3_valid_ff <= 1'b0;
         b4_valid_ff <= 1'b0;
         b5_valid_ff <= 1'b0;
         b6_valid_ff <= 1'b0;
      end else begin
         if (b1_ready) b1_valid_ff <= in_valid;
         if (b2_ready) b2_valid_ff <= b1_valid_ff;
         if (b3_ready) b3_valid_ff <= b2_valid_ff;
         if (b4_ready) b4_valid_ff <= b3_valid_ff;
         if (b5_ready) b5_valid_ff <= b4_valid_ff;
         if (b6_ready) b6_valid_ff <= b5_valid_ff;
      end
   end

   // stage 1: restore the sign of the quotients
   always_comb begin
      for (int l = 0; l < qxmm_pkg::LANES; l++) begin
         b1_mag[l]     = qxmm_pkg::scaled_type'(in_item.work[l]);
         b1_axis_in[l] = in_item.neg[l] ? -b1_mag[l] : b1_mag[l];
      end
   end

   always_ff @(posedge clock) begin
      if (b1_ready && in_valid) begin
         for (int l = 0; l < qxmm_pkg::LANES; l++) b1_axis_ff[l] <= b1_axis_in[l];
         b1_flip_ff  <= in_item.flip;
         b1_thr_ff   <= in_item.thr;
         b1_armed_ff <= in_item.armed;
      end
   end

   // stage 2: rounded scaling is monotonic, so the scaled extremes are the
   // min and max of the scaled axes, swapped when the headroom is negative
   always_comb begin
      if (b1_axis_ff[1] < b1_axis_ff[0]) begin
         lo_a = b1_axis_ff[1];
         hi_a = b1_axis_ff[0];
      end else begin
         lo_a = b1_axis_ff[0];
         hi_a = b1_axis_ff[1];
      end
      if (b1_axis_ff[3] < b1_axis_ff[2]) begin
         lo_b = b1_axis_ff[3];
         hi_b = b1_axis_ff[2];
      end else begin
         lo_b = b1_axis_ff[2];
         hi_b = b1_axis_ff[3];
      end
      lo_m = (lo_b < lo_a) ? lo_b : lo_a;
      hi_m = (hi_b > hi_a) ? hi_b : hi_a;
      if (b1_flip_ff) begin
         b2_lo_in = hi_m;
         b2_hi_in = lo_m;
      end else begin
         b2_lo_in = lo_m;
         b2_hi_in = hi_m;
      end
   end

   always_ff @(posedge clock) begin
      if (b2_ready && b1_valid_ff) begin
         for (int l = 0; l < qxmm_pkg::LANES; l++) b2_axis_ff[l] <= b1_axis_ff[l];
         b2_lo_ff    <= b2_lo_in;
         b2_hi_ff    <= b2_hi_in;
         b2_thr_ff   <= b1_thr_ff;
         b2_armed_ff <= b1_armed_ff;
      end
   end

   // stage 3: throttle floor and ceiling, floor checked first
   always_comb begin
      if (b2_thr_ff > qxmm_pkg::cmd_type'(cfg.desat_throttle)) begin
         floor_v = qxmm_pkg::bound_type'(cfg.idle_level) - qxmm_pkg::bound_type'(b2_lo_ff);
      end else begin
         floor_v = qxmm_pkg::bound_type'(cfg.idle_level);
      end
      ceil_v = qxmm_pkg::bound_type'(cfg.max_level) - qxmm_pkg::bound_type'(b2_hi_ff);
      thr_e  = qxmm_pkg::bound_type'(b2_thr_ff);
      if (thr_e < floor_v) begin
         b3_thr_in = floor_v;
      end else if (thr_e > ceil_v) begin
         b3_thr_in = ceil_v;
      end else begin
         b3_thr_in = thr_e;
      end
   end

   always_ff @(posedge clock) begin
      if (b3_ready && b2_valid_ff) begin
         for (int l = 0; l < qxmm_pkg::LANES; l++) b3_axis_ff[l] <= b2_axis_ff[l];
         b3_thr_ff   <= b3_thr_in;
         b3_armed_ff <= b2_armed_ff;
      end
   end

   // stage 4: motor level, idle..max then at most full scale
   always_comb begin
      idle_e = qxmm_pkg::lvl_type'(cfg.idle_level);
      max_e  = qxmm_pkg::lvl_type'(cfg.max_level);
      for (int l = 0; l < qxmm_pkg::LANES; l++) begin
         lvl[l] = qxmm_pkg::lvl_type'(b3_thr_ff) + qxmm_pkg::lvl_type'(b3_axis_ff[l]);
         if (lvl[l] < idle_e) begin
            bnd[l] = idle_e;
         end else if (lvl[l] > max_e) begin
            bnd[l] = max_e;
         end else begin
            bnd[l] = lvl[l];
         end
         // never negative here: both bounds are unsigned registers
         if (bnd[l] > qxmm_pkg::lvl_type'(qxmm_pkg::ONE_LEVEL)) begin
            bnd[l] = qxmm_pkg::lvl_type'(qxmm_pkg::ONE_LEVEL);
         end
         // disarmed maps to level zero, i.e. pulse_min
         b4_v_in[l] = b3_armed_ff ? bnd[l][qxmm_pkg::LEVEL_W-1:0] : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (b4_ready && b3_valid_ff) begin
         for (int l = 0; l < qxmm_pkg::LANES; l++) b4_v_ff[l] <= b4_v_in[l];
      end
   end

   // stage 5: level times signed pulse span plus one half
   always_comb begin
      span = qxmm_pkg::diff_type'(cfg.pulse_max) - qxmm_pkg::diff_type'(cfg.pulse_min);
      for (int l = 0; l < qxmm_pkg::LANES; l++) begin
         b5_n_in[l] = qxmm_pkg::pwr_type'(b4_v_ff[l]) * qxmm_pkg::pwr_type'(span) +
                      qxmm_pkg::pwr_type'(qxmm_pkg::HALF_LEVEL);
      end
   end

   always_ff @(posedge clock) begin
      if (b5_ready && b4_valid_ff) begin
         for (int l = 0; l < qxmm_pkg::LANES; l++) b5_n_ff[l] <= b5_n_in[l];
      end
   end

   // stage 6: floor divide by full scale, offset by pulse_min
   always_comb begin
      for (int l = 0; l < qxmm_pkg::LANES; l++) begin
         q[l]           = b5_n_ff[l] >>> qxmm_pkg::FRAC_BITS;
         b6_pulse_in[l] = cfg.pulse_min + q[l][qxmm_pkg::PULSE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (b6_ready && b5_valid_ff) begin
         for (int l = 0; l < qxmm_pkg::LANES; l++) b6_pulse_ff[l] <= b6_pulse_in[l];
      end
   end

endmodule

[hdl/quad_x_motor_mixer_desat_top.sv]
// throughput: one request per cycle unless the response side holds off ready;
// eighteen register stages, of which eight form the divider that retires
// four quotient bits per stage
// reset clears all stage valid bits and loads the register defaults
// depends on qxmm_pkg, qxmm_if, qxmm_front, qxmm_div_stage, qxmm_back
`timescale 1ns / 1ps

module quad_x_motor_mixer_desat_top (
   input  logic                                clock,
   input  logic                                reset,
   qxmm_req_if.sink                            req_chan,
   qxmm_rsp_if.source                          rsp_chan,
   input  logic                                csr_we,
   input  logic [qxmm_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [qxmm_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   qxmm_pkg::cfg_type cfg_ff;

   logic [qxmm_pkg::DIV_STAGES:0] div_valid;
   logic [qxmm_pkg::DIV_STAGES:0] div_ready;
   qxmm_pkg::div_type             div_item [qxmm_pkg::DIV_STAGES+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= qxmm_pkg::CFG_RESET;
      end else if (csr_we) begin
         case (qxmm_pkg::csr_index_type'(csr_index))
            qxmm_pkg::CSR_IDLE_LEVEL: begin
               cfg_ff.idle_level <= csr_wdata[qxmm_pkg::CFG_W-1:0];
            end
            qxmm_pkg::CSR_MAX_LEVEL: begin
               cfg_ff.max_level <= csr_wdata[qxmm_pkg::CFG_W-1:0];
            end
            qxmm_pkg::CSR_DESAT_THROTTLE: begin
               cfg_ff.desat_throttle <= csr_wdata[qxmm_pkg::CFG_W-1:0];
            end
            qxmm_pkg::CSR_PULSE_MIN: begin
               cfg_ff.pulse_min <= csr_wdata;
            end
            qxmm_pkg::CSR_PULSE_MAX: begin
               cfg_ff.pulse_max <= csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   qxmm_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req_chan),
      .cfg       (cfg_ff),
      .out_valid (div_valid[0]),
      .out_ready (div_ready[0]),
      .out_item  (div_item[0])
   );

   for (genvar g = 0; g < qxmm_pkg::DIV_STAGES; g++) begin : g_div
      qxmm_div_stage u_stage (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (div_valid[g]),
         .in_ready  (div_ready[g]),
         .in_item   (div_item[g]),
         .out_valid (div_valid[g+1]),
         .out_ready (div_ready[g+1]),
         .out_item  (div_item[g+1])
      );
   end

   qxmm_back u_back (
      .clock    (clock),
      .reset    (reset),
      .in_valid (div_valid[qxmm_pkg::DIV_STAGES]),
      .in_ready (div_ready[qxmm_pkg::DIV_STAGES]),
      .in_item  (div_item[qxmm_pkg::DIV_STAGES]),
      .cfg      (cfg_ff),
      .rsp      (rsp_chan)
   );

`ifndef SYNTH
   // the request side can only stall once every stage up to the output is full
   a_stall_means_full: assert property (@(posedge clock) disable iff (reset)
      !req_chan.ready |-> (rsp_chan.valid && !rsp_chan.ready))
      else $error("request side stalled with a free pipeline stage");

   // a finished division leaves every remainder below the divisor
   a_div_remainder: assert property (@(posedge clock) disable iff (reset)
      div_valid[qxmm_pkg::DIV_STAGES] |->
         (div_item[qxmm_pkg::DIV_STAGES].rem[0] < div_item[qxmm_pkg::DIV_STAGES].den) &&
         (div_item[qxmm_pkg::DIV_STAGES].rem[1] < div_item[qxmm_pkg::DIV_STAGES].den) &&
         (div_item[qxmm_pkg::DIV_STAGES].rem[2] < div_item[qxmm_pkg::DIV_STAGES].den) &&
         (div_item[qxmm_pkg::DIV_STAGES].rem[3] < div_item[qxmm_pkg::DIV_STAGES].den))
      else $error("divider remainder not below divisor");

   a_pulse_max_write: assert property (@(posedge clock) disable iff (reset)
      (csr_we && (csr_index == qxmm_pkg::CSR_PULSE_MAX)) |=>
         (cfg_ff.pulse_max == $past(csr_wdata)))
      else $error("pulse_max register write lost");
`endif

endmodule

[test/qxmm_checker.sv]
// qxmm_checker: watches the request, response and register ports of the motor mixer,
// computes the four expected pulse values of every request and compares them in order.
// depends on qxmm_pkg and the channel interfaces in qxmm_if
`timescale 1ns / 1ps

module qxmm_checker (
   input  logic                              clock,
   input  logic                              reset,
   qxmm_req_if                               req_mon,
   qxmm_rsp_if                               rsp_mon,
   input  logic                              csr_we,
   input  logic [qxmm_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [qxmm_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output int                                fail_count,
   output int                                pending,
   output int                                checked
);

   typedef logic [qxmm_pkg::LANES-1:0][qxmm_pkg::PULSE_W-1:0] motor_pulses_type;

   localparam int REPORT_LIMIT = 10;

   qxmm_pkg::cfg_type cfg_model = qxmm_pkg::CFG_RESET;
   motor_pulses_type  motor_pulse_q [$];
   int                errors = 0;
   int                compared = 0;
   string             motor_name [qxmm_pkg::LANES] =
                         '{"front right", "rear right", "rear left", "front left"};

   function automatic longint clip(longint v, longint lo, longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   // a * num / den, den positive, rounded to nearest with ties away from zero
   function automatic longint scale_round(longint a, longint num, longint den);
      longint prod;
      longint mag;
      longint q;
      prod = a * num;
      mag  = (prod < 0) ? -prod : prod;
      q    = (mag + den / 2) / den;
      return (prod < 0) ? -q : q;
   endfunction

   function automatic qxmm_pkg::pulse_type level_to_pulse(longint level,
                                                          qxmm_pkg::cfg_type c);
      longint v;
      longint span;
      longint n;
      longint q;
      v    = clip(level, 0, qxmm_pkg::ONE_LEVEL);
      span = longint'(c.pulse_max) - longint'(c.pulse_min);
      n    = v * span + qxmm_pkg::HALF_LEVEL;
      // floor division, span goes negative when pulse_max is below pulse_min
      q    = (n >= 0) ? n / qxmm_pkg::ONE_LEVEL :
             -((-n + qxmm_pkg::ONE_LEVEL - 1) / qxmm_pkg::ONE_LEVEL);
      return qxmm_pkg::pulse_type'(longint'(c.pulse_min) + q);
   endfunction

   function automatic motor_pulses_type predict_pulses(qxmm_pkg::cmd_type roll,
                                                       qxmm_pkg::cmd_type pitch,
                                                       qxmm_pkg::cmd_type yaw,
                                                       qxmm_pkg::cmd_type throttle,
                                                       logic armed,
                                                       qxmm_pkg::cfg_type c);
      longint           r;
      longint           p;
      longint           y;
      longint           thr;
      longint           idle;
      longint           max_lvl;
      longint           lo;
      longint           hi;
      longint           avail;
      longint           spread;
      longint           floor_lvl;
      longint           mixed [qxmm_pkg::LANES];
      motor_pulses_type pulses;
      int               i;
      r       = roll;
      p       = pitch;
      y       = yaw;
      thr     = throttle;
      idle    = longint'(c.idle_level);
      max_lvl = longint'(c.max_level);
      if (!armed) begin
         for (i = 0; i < qxmm_pkg::LANES; i++) pulses[i] = level_to_pulse(0, c);
         return pulses;
      end
      mixed[0] = -r + p + y;
      mixed[1] = -r - p - y;
      mixed[2] =  r - p + y;
      mixed[3] =  r + p - y;
      lo = mixed[0];
      hi = mixed[0];
      for (i = 1; i < qxmm_pkg::LANES; i++) begin
         if (mixed[i] < lo) lo = mixed[i];
         if (mixed[i] > hi) hi = mixed[i];
      end
      avail  = max_lvl - idle;
      spread = hi - lo;
      // squeeze the attitude part into the idle..max span; negative avail flips it
      if (spread > avail && spread > 0) begin
         for (i = 0; i < qxmm_pkg::LANES; i++)
            mixed[i] = scale_round(mixed[i], avail, spread);
         lo = scale_round(lo, avail, spread);
         hi = scale_round(hi, avail, spread);
      end
      floor_lvl = (thr > longint'(c.desat_throttle)) ? idle - lo : idle;
      thr = clip(thr, floor_lvl, max_lvl - hi);
      for (i = 0; i < qxmm_pkg::LANES; i++)
         pulses[i] = level_to_pulse(clip(thr + mixed[i], idle, max_lvl), c);
      return pulses;
   endfunction

   always @(posedge clock) begin : monitor
      motor_pulses_type got;
      motor_pulses_type want;
      int               i;
      if (reset) begin
         cfg_model = qxmm_pkg::CFG_RESET;
      end else begin
         if (req_mon.valid && req_mon.ready) begin
            motor_pulse_q.push_back(predict_pulses(req_mon.roll_cmd, req_mon.pitch_cmd,
                                                   req_mon.yaw_cmd, req_mon.throttle_cmd,
                                                   req_mon.armed, cfg_model));
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            got[0] = rsp_mon.pulse_front_right;
            got[1] = rsp_mon.pulse_rear_right;
            got[2] = rsp_mon.pulse_rear_left;
            got[3] = rsp_mon.pulse_front_left;
            if (motor_pulse_q.size() == 0) begin
               if (errors < REPORT_LIMIT)
                  $display("response with no request waiting: %0d %0d %0d %0d",
                           got[0], got[1], got[2], got[3]);
               errors++;
            end else begin
               want = motor_pulse_q.pop_front();
               for (i = 0; i < qxmm_pkg::LANES; i++) begin
                  if (got[i] !== want[i]) begin
                     if (errors < REPORT_LIMIT)
                        $display("response %0d, %s pulse: expected %0d, got %0d",
                                 compared, motor_name[i], want[i], got[i]);
                     errors++;
                  end
               end
               compared++;
            end
         end
         if (csr_we) begin
            case (csr_index)
               qxmm_pkg::CSR_IDLE_LEVEL:
                  cfg_model.idle_level     = csr_wdata[qxmm_pkg::CFG_W-1:0];
               qxmm_pkg::CSR_MAX_LEVEL:
                  cfg_model.max_level      = csr_wdata[qxmm_pkg::CFG_W-1:0];
               qxmm_pkg::CSR_DESAT_THROTTLE:
                  cfg_model.desat_throttle = csr_wdata[qxmm_pkg::CFG_W-1:0];
               qxmm_pkg::CSR_PULSE_MIN:
                  cfg_model.pulse_min      = csr_wdata;
               qxmm_pkg::CSR_PULSE_MAX:
                  cfg_model.pulse_max      = csr_wdata;
               default: ;
            endcase
         end
      end
      fail_count <= errors;
      pending    <= motor_pulse_q.size();
      checked    <= compared;
   end

endmodule

[test/quad_x_motor_mixer_desat_top_tb.sv]
// quad_x_motor_mixer_desat_top_tb: drives attitude requests and register settings into
// the motor mixer under random flow control and reports the verdict of qxmm_checker.
// depends on qxmm_pkg, qxmm_if, qxmm_checker and the mixer rtl
`timescale 1ns / 1ps

module quad_x_motor_mixer_desat_top_tb;

   localparam int NUM_PHASES      = 12;
   localparam int ITEMS_PER_PHASE = 96;
   localparam int NUM_DIRECTED    = 22;
   localparam int HOLD_CYCLES     = 300;
   localparam int STALL_LIMIT     = 2000;
   localparam int DRAIN_TAIL      = 40;

   localparam qxmm_pkg::cmd_type CMD_MAX = 16'sh7fff;
   localparam qxmm_pkg::cmd_type CMD_MIN = 16'sh8000;

   typedef struct packed {
      qxmm_pkg::cmd_type roll;
      qxmm_pkg::cmd_type pitch;
      qxmm_pkg::cmd_type yaw;
      qxmm_pkg::cmd_type throttle;
      logic              armed;
   } attitude_cmd_type;

   logic                            clock;
   logic                            reset;
   logic                            csr_we;
   logic [qxmm_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [qxmm_pkg::CSR_DATA_W-1:0] csr_wdata;

   int fail_count;
   int pending;
   int checked;
   int sent = 0;
   int idle_cycles = 0;
   bit hold_rsp = 1'b0;
   bit steady = 1'b0;

   qxmm_req_if req_if ();
   qxmm_rsp_if rsp_if ();

   quad_x_motor_mixer_desat_top u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_if),
      .rsp_chan  (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   qxmm_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_if),
      .rsp_mon    (rsp_if),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .fail_count (fail_count),
      .pending    (pending),
      .checked    (checked)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (steady || hold_rsp) return 0;
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic qxmm_pkg::cmd_type corner_value();
      case ($urandom_range(0, 5))
         0:       return CMD_MAX;
         1:       return CMD_MIN;
         2:       return qxmm_pkg::cmd_type'(0);
         3:       return qxmm_pkg::cmd_type'(-1);
         4:       return qxmm_pkg::cmd_type'(1);
         default: return qxmm_pkg::cmd_type'(qxmm_pkg::ONE_LEVEL);
      endcase
   endfunction

   function automatic attitude_cmd_type directed_command(int k);
      attitude_cmd_type c;
      case (k)
         0:  c = '{0, 0, 0, 0, 1'b1};
         1:  c = '{CMD_MAX, CMD_MAX, CMD_MAX, CMD_MAX, 1'b0};
         2:  c = '{CMD_MIN, CMD_MIN, CMD_MIN, CMD_MIN, 1'b0};
         3:  c = '{CMD_MAX, 0, 0, 8192, 1'b1};
         4:  c = '{CMD_MIN, 0, 0, 8192, 1'b1};
         5:  c = '{0, CMD_MAX, 0, 8192, 1'b1};
         6:  c = '{0, CMD_MIN, 0, 8192, 1'b1};
         7:  c = '{0, 0, CMD_MAX, 8192, 1'b1};
         8:  c = '{0, 0, CMD_MIN, 8192, 1'b1};
         9:  c = '{0, 0, 0, qxmm_pkg::ONE_LEVEL, 1'b1};
         10: c = '{0, 0, 0, CMD_MAX, 1'b1};
         11: c = '{0, 0, 0, CMD_MIN, 1'b1};
         // throttle on the lift threshold, then one above it
         12: c = '{4000, 0, 0, 819, 1'b1};
         13: c = '{4000, 0, 0, 820, 1'b1};
         14: c = '{CMD_MAX, CMD_MAX, CMD_MAX, CMD_MAX, 1'b1};
         15: c = '{CMD_MIN, CMD_MIN, CMD_MIN, CMD_MIN, 1'b1};
         16: c = '{CMD_MAX, CMD_MIN, CMD_MAX, 8192, 1'b1};
         // spread equal to the usable span, then two past it
         17: c = '{8192, 0, 0, 8192, 1'b1};
         18: c = '{8193, 0, 0, 8192, 1'b1};
         19: c = '{2000, -3000, 1500, 16000, 1'b1};
         20: c = '{3, 5, 7, 100, 1'b1};
         default: c = '{-1, -1, -1, 1, 1'b1};
      endcase
      return c;
   endfunction

   function automatic attitude_cmd_type random_command(qxmm_pkg::frac_type desat);
      attitude_cmd_type c;
      int               sel;
      sel     = $urandom_range(0, 99);
      c.armed = ($urandom_range(0, 9) != 0);
      if (sel < 50) begin
         // hover-like corrections
         c.roll     = qxmm_pkg::cmd_type'(int'($urandom_range(0, 8000)) - 4000);
         c.pitch    = qxmm_pkg::cmd_type'(int'($urandom_range(0, 8000)) - 4000);
         c.yaw      = qxmm_pkg::cmd_type'(int'($urandom_range(0, 8000)) - 4000);
         c.throttle = qxmm_pkg::cmd_type'($urandom_range(0, qxmm_pkg::ONE_LEVEL));
      end else if (sel < 65) begin
         // hard maneuvers, spread well past the usable span
         c.roll     = qxmm_pkg::cmd_type'(int'($urandom_range(0, 40000)) - 20000);
         c.pitch    = qxmm_pkg::cmd_type'(int'($urandom_range(0, 40000)) - 20000);
         c.yaw      = qxmm_pkg::cmd_type'(int'($urandom_range(0, 40000)) - 20000);
         c.throttle = qxmm_pkg::cmd_type'($urandom_range(0, qxmm_pkg::ONE_LEVEL));
      end else if (sel < 75) begin
         c.roll     = qxmm_pkg::cmd_type'(int'($urandom_range(0, 4000)) - 2000);
         c.pitch    = qxmm_pkg::cmd_type'(int'($urandom_range(0, 4000)) - 2000);
         c.yaw      = qxmm_pkg::cmd_type'(int'($urandom_range(0, 4000)) - 2000);
         c.throttle = qxmm_pkg::cmd_type'(int'(desat) + int'($urandom_range(0, 6)) - 3);
      end else if (sel < 82) begin
         c.roll     = corner_value();
         c.pitch    = corner_value();
         c.yaw      = corner_value();
         c.throttle = corner_value();
      end else begin
         c.roll     = qxmm_pkg::cmd_type'($urandom);
         c.pitch    = qxmm_pkg::cmd_type'($urandom);
         c.yaw      = qxmm_pkg::cmd_type'($urandom);
         c.throttle = qxmm_pkg::cmd_type'($urandom);
         c.armed    = 1'($urandom_range(0, 1));
      end
      return c;
   endfunction

   function automatic qxmm_pkg::cfg_type setting_for_phase(int p);
      qxmm_pkg::cfg_type s;
      s = qxmm_pkg::CFG_RESET;
      case (p)
         1: ;
         2: s = '{15'd0, 15'h7fff, 15'd0, 16'd0, 16'hffff};
         // idle above max with the pulse range reversed
         3: s = '{15'h7fff, 15'd0, 15'h7fff, 16'hffff, 16'd0};
         4: s = '{15'd16384, 15'd16384, 15'd16384, 16'd1000, 16'd2000};
         5: s = '{15'd0, 15'd0, 15'd0, 16'd0, 16'd0};
         6: s = '{15'h7fff, 15'h7fff, 15'h7fff, 16'hffff, 16'hffff};
         7: s = '{15'd1638, 15'd15565, 15'd819, 16'd1000, 16'd2000};
         8: s = '{15'd6000, 15'd3000, 15'd2000, 16'd2000, 16'd1000};
         default: begin
            if ($urandom_range(0, 1)) begin
               s.idle_level     = qxmm_pkg::frac_type'($urandom_range(0, 3000));
               s.max_level      = qxmm_pkg::frac_type'($urandom_range(12000,
                                                                      qxmm_pkg::ONE_LEVEL));
               s.desat_throttle = qxmm_pkg::frac_type'($urandom_range(0, 4000));
               s.pulse_min      = qxmm_pkg::pulse_type'($urandom_range(900, 1100));
               s.pulse_max      = qxmm_pkg::pulse_type'($urandom_range(1900, 2100));
            end else begin
               s.idle_level     = qxmm_pkg::frac_type'($urandom);
               s.max_level      = qxmm_pkg::frac_type'($urandom);
               s.desat_throttle = qxmm_pkg::frac_type'($urandom);
               s.pulse_min      = qxmm_pkg::pulse_type'($urandom);
               s.pulse_max      = qxmm_pkg::pulse_type'($urandom);
            end
         end
      endcase
      return s;
   endfunction

   task automatic send_command(attitude_cmd_type c);
      req_if.valid        <= 1'b1;
      req_if.roll_cmd     <= c.roll;
      req_if.pitch_cmd    <= c.pitch;
      req_if.yaw_cmd      <= c.yaw;
      req_if.throttle_cmd <= c.throttle;
      req_if.armed        <= c.armed;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      sent++;
   endtask

   task automatic idle_gap(int n);
      if (n > 0) begin
         req_if.valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   // stop offering and wait out every response still owed
   task automatic drain();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   task automatic write_register(qxmm_pkg::csr_index_type idx,
                                 logic [qxmm_pkg::CSR_DATA_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   // the unused top bit of the narrow registers is toggled too
   task automatic load_setting(qxmm_pkg::cfg_type s);
      write_register(qxmm_pkg::CSR_IDLE_LEVEL,
                     {1'($urandom_range(0, 1)), s.idle_level});
      write_register(qxmm_pkg::CSR_MAX_LEVEL,
                     {1'($urandom_range(0, 1)), s.max_level});
      write_register(qxmm_pkg::CSR_DESAT_THROTTLE,
                     {1'($urandom_range(0, 1)), s.desat_throttle});
      write_register(qxmm_pkg::CSR_PULSE_MIN, s.pulse_min);
      write_register(qxmm_pkg::CSR_PULSE_MAX, s.pulse_max);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // response side flow control
   initial begin
      int gap;
      rsp_if.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_rsp) begin
            rsp_if.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_rsp = 1'b0;
         end
         rsp_if.ready <= 1'b1;
         repeat ($urandom_range(1, 30)) @(posedge clock);
         gap = pick_gap();
         if (gap > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin
      int                p;
      int                k;
      int                quota;
      int                in_phase;
      qxmm_pkg::cfg_type s;
      reset               <= 1'b1;
      csr_we              <= 1'b0;
      csr_index           <= qxmm_pkg::CSR_IDLE_LEVEL;
      csr_wdata           <= '0;
      req_if.valid        <= 1'b0;
      req_if.roll_cmd     <= '0;
      req_if.pitch_cmd    <= '0;
      req_if.yaw_cmd      <= '0;
      req_if.throttle_cmd <= '0;
      req_if.armed        <= 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      s = qxmm_pkg::CFG_RESET;
      for (k = 0; k < NUM_DIRECTED; k++) begin
         idle_gap(pick_gap());
         send_command(directed_command(k));
      end

      for (p = 0; p < NUM_PHASES; p++) begin
         if (p > 0) begin
            drain();
            s = setting_for_phase(p);
            load_setting(s);
         end
         quota    = (p == 0) ? ITEMS_PER_PHASE - NUM_DIRECTED : ITEMS_PER_PHASE;
         hold_rsp = (p == 1);
         steady   = (p == 4);
         in_phase = 0;
         // keep offering while the response side is held off
         while (in_phase < quota || hold_rsp) begin
            if (p == 6 && in_phase == quota / 2) drain();
            idle_gap(pick_gap());
            send_command(random_command(s.desat_throttle));
            in_phase++;
         end
      end

      drain();
      repeat (DRAIN_TAIL) @(posedge clock);
      $display("covered %0d requests under %0d register settings, %0d responses checked",
               sent, NUM_PHASES, checked);
      $display("flow control included a %0d-cycle response hold-off and a mid-run drain",
               HOLD_CYCLES);
      if (fail_count == 0 && pending == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
